### design/emfc_pkg.sv
// ----------------------------------------------------------------------------
// emfc_pkg
// shared types, constants and helper functions for the frame checker
// ----------------------------------------------------------------------------
package emfc_pkg;

  // result kinds, carried on the result tuser
  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_OK    = 3'd1,
    KIND_BAD   = 3'd2,
    KIND_FMT   = 3'd3,
    KIND_ABORT = 3'd4
  } kind_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 14;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned CrcDigits = 4;

  // result tdata: data_byte, frame_length, computed_crc, padded to bytes
  localparam int unsigned ResFieldsW = ByteW + LenW + CrcW;
  localparam int unsigned ResDataW   = ((ResFieldsW + 7) / 8) * 8;

  localparam logic [LenW-1:0]  LenMax   = 14'd16383;
  localparam logic [CrcW-1:0]  CrcInit  = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly  = 16'hA001;
  localparam logic [ByteW-1:0] HashChar = 8'h23;

  // crc-16/modbus update over one byte, lsb first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // decimal digit decode: {valid, value}
  function automatic logic [4:0] dec_digit(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = c - 8'h30;
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // hex digit decode, either case: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

### design/env_monitor_frame_checker.sv
// ----------------------------------------------------------------------------
// env_monitor_frame_checker
// Deframer and CRC-16/MODBUS checker for "##LLLL<payload>CCCC" byte frames.
// One received byte is taken per transfer on the slave side. The block hunts
// for two '#' in a row, reads LENGTH_DIGITS decimal length digits, forwards
// that many payload bytes (kind 0) while running CRC-16/MODBUS, then reads
// four hex digits and reports frame ok (1) or crc mismatch (2). A bad digit
// gives a format error (3); tlast on a byte that leaves a frame open gives
// an abort (4). Bytes outside a frame yield no result. The frame state and
// the byte-wide crc update sit between the input handshake and one result
// register, so a new byte is accepted every cycle unless a held result is
// stalled by the master side. Results appear in the cycle after the byte
// that caused them.
// ----------------------------------------------------------------------------
module env_monitor_frame_checker #(
  parameter int unsigned LENGTH_DIGITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: tdata = rx_byte[7:0]; tlast = chunk_end
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [emfc_pkg::ByteW-1:0]    s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  // master side: tdata = data_byte[7:0], frame_length[21:8],
  //   computed_crc[37:22], zero pad[39:38]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [emfc_pkg::ResDataW-1:0] m_axis_tdata_o,
  // master side: tuser = kind[2:0]
  output logic [2:0]                    m_axis_tuser_o
);
  import emfc_pkg::*;

  // digit counter covers both the length field and the crc field
  localparam int unsigned DigitMax = (LENGTH_DIGITS > CrcDigits) ? LENGTH_DIGITS : CrcDigits;
  localparam int unsigned DigitW   = $clog2(DigitMax + 1);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  // frame state
  phase_e              phase_q, phase_d;
  logic [DigitW-1:0]   digit_q, digit_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic [CrcW-1:0]     crc_q, crc_d;
  logic [CrcW-1:0]     rxcrc_q, rxcrc_d;

  // result register
  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [ByteW-1:0]    out_data_q;
  logic [LenW-1:0]     out_len_q;
  logic [CrcW-1:0]     out_crc_q;

  logic                in_xfer;
  logic                res_valid;
  kind_e               res_kind;
  logic [ByteW-1:0]    res_data;
  logic [DigitW-1:0]   digit_inc;
  logic [4:0]          dec;
  logic [4:0]          hex;
  logic [LenW+3:0]     len_acc;
  logic [LenW-1:0]     len_sat;
  logic [CrcW-1:0]     rxcrc_shift;

  // a held result only blocks input when the master side stalls it
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign digit_inc   = digit_q + DigitW'(1);
  assign dec         = dec_digit(s_axis_tdata_i);
  assign hex         = hex_digit(s_axis_tdata_i);
  // length * 10 + digit, saturating to the field width
  assign len_acc     = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {14'd0, dec[3:0]};
  assign len_sat     = (len_acc > {4'd0, LenMax}) ? LenMax : len_acc[LenW-1:0];
  assign rxcrc_shift = {rxcrc_q[CrcW-5:0], hex[3:0]};

  always_comb begin
    phase_d   = phase_q;
    digit_d   = digit_q;
    len_d     = len_q;
    rem_d     = rem_q;
    crc_d     = crc_q;
    rxcrc_d   = rxcrc_q;
    res_valid = 1'b0;
    res_kind  = KIND_BYTE;
    res_data  = '0;

    case (phase_q)
      PH_HUNT1: begin
        if (s_axis_tdata_i == HashChar) begin
          phase_d = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        // second hash opens a frame and clears its context
        if (s_axis_tdata_i == HashChar) begin
          phase_d = PH_LEN;
          digit_d = '0;
          len_d   = '0;
          rem_d   = '0;
          crc_d   = CrcInit;
          rxcrc_d = '0;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_LEN: begin
        if (!dec[4]) begin
          res_valid = 1'b1;
          res_kind  = KIND_FMT;
          phase_d   = PH_HUNT1;
        end else begin
          len_d   = len_sat;
          digit_d = digit_inc;
          if (digit_inc >= DigitW'(LENGTH_DIGITS)) begin
            digit_d = '0;
            rem_d   = len_sat;
            phase_d = (len_sat == '0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_d     = crc_byte(crc_q, s_axis_tdata_i);
        res_valid = 1'b1;
        res_kind  = KIND_BYTE;
        res_data  = s_axis_tdata_i;
        rem_d     = rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          phase_d = PH_CRC;
          digit_d = '0;
        end
      end
      PH_CRC: begin
        if (!hex[4]) begin
          res_valid = 1'b1;
          res_kind  = KIND_FMT;
          phase_d   = PH_HUNT1;
        end else begin
          rxcrc_d = rxcrc_shift;
          digit_d = digit_inc;
          if (digit_inc >= DigitW'(CrcDigits)) begin
            digit_d   = '0;
            res_valid = 1'b1;
            res_kind  = (rxcrc_shift == crc_q) ? KIND_OK : KIND_BAD;
            phase_d   = PH_HUNT1;
          end
        end
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase

    // chunk end: a frame still open after this byte is aborted
    if (s_axis_tlast_i) begin
      if (phase_d == PH_LEN || phase_d == PH_PAYLOAD || phase_d == PH_CRC) begin
        res_valid = 1'b1;
        res_kind  = KIND_ABORT;
        res_data  = '0;
      end
      phase_d = PH_HUNT1;
      digit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      digit_q     <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      crc_q       <= CrcInit;
      rxcrc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q <= phase_d;
        digit_q <= digit_d;
        len_q   <= len_d;
        rem_q   <= rem_d;
        crc_q   <= crc_d;
        rxcrc_q <= rxcrc_d;
      end
      if (in_xfer && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
      out_len_q  <= (res_kind == KIND_BYTE) ? '0 : len_d;
      out_crc_q  <= (res_kind == KIND_BYTE) ? '0 : crc_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {(ResDataW - ResFieldsW)'(0), out_crc_q, out_len_q, out_data_q};

  // payload phase always has bytes left to forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

  // length digit counter stays inside the length field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN) |-> (digit_q < DigitW'(LENGTH_DIGITS)))
    else $error("length digit counter out of range");

  // a payload byte without chunk end always yields a byte result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && phase_q == PH_PAYLOAD && !s_axis_tlast_i)
      |=> (out_valid_q && out_kind_q == KIND_BYTE
           && out_data_q == $past(s_axis_tdata_i)))
    else $error("payload byte not forwarded");

  // byte results carry no length or crc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_BYTE) |-> (out_len_q == '0 && out_crc_q == '0))
    else $error("byte result with verdict fields set");

  // outside a frame the running context is idle after chunk end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> (phase_q == PH_HUNT1 && digit_q == '0))
    else $error("chunk end did not return to hunting");

endmodule
